// File: design/two_channel_volt_autorange_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-channel vertical autorange block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_VOLT_AUTORANGE_CORE_MACROS_SVH
`define TWO_CHANNEL_VOLT_AUTORANGE_CORE_MACROS_SVH

// This assertion is checked only while reset is released.
`define TCVA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// This assertion is also checked while reset is held.
`define TCVA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// File: design/tcva_pkg.sv
// ----------------------------------------------------------------------------
// tcva_pkg
// Shared widths, register map, reset values and types of the autorange block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcva_pkg;

    localparam int SAMPLE_W = 8;
    localparam int CODE_W   = 4;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;

    // Tracker values at the start of an acquisition.
    localparam logic [SAMPLE_W-1:0] TRACK_LOW_INIT  = 8'hFF;
    localparam logic [SAMPLE_W-1:0] TRACK_HIGH_INIT = 8'h00;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [REG_IDX_W-1:0] {
        REG_RANGING_ENABLE  = 3'd0,
        REG_CLIP_LOW        = 3'd1,
        REG_CLIP_HIGH       = 3'd2,
        REG_QUIET_LOW       = 3'd3,
        REG_QUIET_HIGH      = 3'd4,
        REG_LEAST_SENS_CODE = 3'd5,
        REG_MOST_SENS_CODE  = 3'd6,
        REG_OFF_CODE        = 3'd7
    } t_reg_idx;

    // Reset values of the configuration registers.
    localparam logic                RST_RANGING_ENABLE  = 1'b1;
    localparam logic [SAMPLE_W-1:0] RST_CLIP_LOW        = 8'd8;
    localparam logic [SAMPLE_W-1:0] RST_CLIP_HIGH       = 8'd247;
    localparam logic [SAMPLE_W-1:0] RST_QUIET_LOW       = 8'd64;
    localparam logic [SAMPLE_W-1:0] RST_QUIET_HIGH      = 8'd191;
    localparam logic [CODE_W-1:0]   RST_LEAST_SENS_CODE = 4'd0;
    localparam logic [CODE_W-1:0]   RST_MOST_SENS_CODE  = 4'd11;
    localparam logic [CODE_W-1:0]   RST_OFF_CODE        = 4'd15;

    typedef struct packed {
        logic                ranging_enable;
        logic [SAMPLE_W-1:0] clip_low;
        logic [SAMPLE_W-1:0] clip_high;
        logic [SAMPLE_W-1:0] quiet_low;
        logic [SAMPLE_W-1:0] quiet_high;
        logic [CODE_W-1:0]   least_sens_code;
        logic [CODE_W-1:0]   most_sens_code;
        logic [CODE_W-1:0]   off_code;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic                last_sample;
        logic [CODE_W-1:0]   range_code_a;
        logic [CODE_W-1:0]   range_code_b;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              changed;
    } t_chan_res;

endpackage

`default_nettype wire

// File: design/tcva_stream_if.sv
// ----------------------------------------------------------------------------
// tcva_in_if / tcva_out_if
// Valid/ready channels carrying sample requests in and ranging results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcva_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcva_pkg::SAMPLE_W-1:0] sample_a;
    logic [tcva_pkg::SAMPLE_W-1:0] sample_b;
    logic                          last_sample;
    logic [tcva_pkg::CODE_W-1:0]   range_code_a;
    logic [tcva_pkg::CODE_W-1:0]   range_code_b;

    modport source (output valid, sample_a, sample_b, last_sample,
                    range_code_a, range_code_b, input ready);
    modport sink   (input valid, sample_a, sample_b, last_sample,
                    range_code_a, range_code_b, output ready);
endinterface

interface tcva_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcva_pkg::CODE_W-1:0] new_code_a;
    logic [tcva_pkg::CODE_W-1:0] new_code_b;
    logic                        changed_a;
    logic                        changed_b;
    logic                        ranging_done;

    modport source (output valid, new_code_a, new_code_b, changed_a, changed_b,
                    ranging_done, input ready);
    modport sink   (input valid, new_code_a, new_code_b, changed_a, changed_b,
                    ranging_done, output ready);
endinterface

`default_nettype wire

// File: design/two_channel_volt_autorange_core.sv
// Results: a last-marked request passes through the input register, then the result register.
// Throughput: one sample request per cycle; only compares sit between the input
// register and the result register, so the input side stalls only while a result
// waits in the result register and the next last-marked request needs it.
// Reset: synchronous, active low; empties both stages and sets both trackers and the registers to their start values.
// ----------------------------------------------------------------------------
// two_channel_volt_autorange_core
// Two-channel vertical autorange: tracks per-acquisition extremes and steps
// each channel's sensitivity code at most once per acquisition.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_channel_volt_autorange_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tcva_in_if.sink                             i_in,
    tcva_out_if.source                          o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tcva_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tcva_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tcva_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    tcva_pkg::t_cfg        cfg;
    tcva_pkg::t_in_item    r_in;
    logic                  r_in_valid;
    logic                  advance;
    logic                  in_ready;
    logic                  accept_in;
    logic                  out_load;
    tcva_pkg::t_chan_res   res_a;
    tcva_pkg::t_chan_res   res_b;
    tcva_pkg::t_chan_res   r_res_a;
    tcva_pkg::t_chan_res   r_res_b;
    logic                  r_done;
    logic                  r_out_valid;

    tcva_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: a held request moves on unless it needs the result slot and that
    // slot is full and stalled.
    assign advance   = r_in_valid && (!r_in.last_sample || !r_out_valid || o_out.ready);
    assign in_ready  = !r_in_valid || advance;
    assign accept_in = i_in.valid && in_ready;
    assign out_load  = advance && r_in.last_sample;
    assign i_in.ready = in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in.sample_a     <= i_in.sample_a;
            r_in.sample_b     <= i_in.sample_b;
            r_in.last_sample  <= i_in.last_sample;
            r_in.range_code_a <= i_in.range_code_a;
            r_in.range_code_b <= i_in.range_code_b;
        end
    end

    // Per-channel trackers and decisions.
    tcva_channel u_chan_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_last   (r_in.last_sample),
        .i_sample (r_in.sample_a),
        .i_code   (r_in.range_code_a),
        .i_cfg    (cfg),
        .o_res    (res_a)
    );

    tcva_channel u_chan_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_last   (r_in.last_sample),
        .i_sample (r_in.sample_b),
        .i_code   (r_in.range_code_b),
        .i_cfg    (cfg),
        .o_res    (res_b)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res_a <= res_a;
            r_res_b <= res_b;
            r_done  <= cfg.ranging_enable;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.new_code_a   = r_res_a.code;
    assign o_out.new_code_b   = r_res_b.code;
    assign o_out.changed_a    = r_res_a.changed;
    assign o_out.changed_b    = r_res_b.changed;
    assign o_out.ranging_done = r_done;

endmodule

`default_nettype wire

// File: design/tcva_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcva_cfg_regs
// APB-style register file holding the ranging thresholds and code limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcva_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tcva_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tcva_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tcva_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output tcva_pkg::t_cfg                      o_cfg
);

    tcva_pkg::t_cfg       r_cfg;
    tcva_pkg::t_reg_idx   reg_idx;
    logic                 wr_en;

    assign reg_idx = tcva_pkg::t_reg_idx'(paddr[tcva_pkg::PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ranging_enable  <= tcva_pkg::RST_RANGING_ENABLE;
            r_cfg.clip_low        <= tcva_pkg::RST_CLIP_LOW;
            r_cfg.clip_high       <= tcva_pkg::RST_CLIP_HIGH;
            r_cfg.quiet_low       <= tcva_pkg::RST_QUIET_LOW;
            r_cfg.quiet_high      <= tcva_pkg::RST_QUIET_HIGH;
            r_cfg.least_sens_code <= tcva_pkg::RST_LEAST_SENS_CODE;
            r_cfg.most_sens_code  <= tcva_pkg::RST_MOST_SENS_CODE;
            r_cfg.off_code        <= tcva_pkg::RST_OFF_CODE;
        end else if (wr_en) begin
            case (reg_idx)
                tcva_pkg::REG_RANGING_ENABLE: begin
                    r_cfg.ranging_enable <= pwdata[0];
                end
                tcva_pkg::REG_CLIP_LOW: begin
                    r_cfg.clip_low <= pwdata[tcva_pkg::SAMPLE_W-1:0];
                end
                tcva_pkg::REG_CLIP_HIGH: begin
                    r_cfg.clip_high <= pwdata[tcva_pkg::SAMPLE_W-1:0];
                end
                tcva_pkg::REG_QUIET_LOW: begin
                    r_cfg.quiet_low <= pwdata[tcva_pkg::SAMPLE_W-1:0];
                end
                tcva_pkg::REG_QUIET_HIGH: begin
                    r_cfg.quiet_high <= pwdata[tcva_pkg::SAMPLE_W-1:0];
                end
                tcva_pkg::REG_LEAST_SENS_CODE: begin
                    r_cfg.least_sens_code <= pwdata[tcva_pkg::CODE_W-1:0];
                end
                tcva_pkg::REG_MOST_SENS_CODE: begin
                    r_cfg.most_sens_code <= pwdata[tcva_pkg::CODE_W-1:0];
                end
                tcva_pkg::REG_OFF_CODE: begin
                    r_cfg.off_code <= pwdata[tcva_pkg::CODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux, zero-extended to the data width.
    always_comb begin
        case (reg_idx)
            tcva_pkg::REG_RANGING_ENABLE:
                prdata = {{(tcva_pkg::PDATA_W-1){1'b0}}, r_cfg.ranging_enable};
            tcva_pkg::REG_CLIP_LOW:
                prdata = {{(tcva_pkg::PDATA_W-tcva_pkg::SAMPLE_W){1'b0}}, r_cfg.clip_low};
            tcva_pkg::REG_CLIP_HIGH:
                prdata = {{(tcva_pkg::PDATA_W-tcva_pkg::SAMPLE_W){1'b0}}, r_cfg.clip_high};
            tcva_pkg::REG_QUIET_LOW:
                prdata = {{(tcva_pkg::PDATA_W-tcva_pkg::SAMPLE_W){1'b0}}, r_cfg.quiet_low};
            tcva_pkg::REG_QUIET_HIGH:
                prdata = {{(tcva_pkg::PDATA_W-tcva_pkg::SAMPLE_W){1'b0}}, r_cfg.quiet_high};
            tcva_pkg::REG_LEAST_SENS_CODE:
                prdata = {{(tcva_pkg::PDATA_W-tcva_pkg::CODE_W){1'b0}},
                          r_cfg.least_sens_code};
            tcva_pkg::REG_MOST_SENS_CODE:
                prdata = {{(tcva_pkg::PDATA_W-tcva_pkg::CODE_W){1'b0}},
                          r_cfg.most_sens_code};
            tcva_pkg::REG_OFF_CODE:
                prdata = {{(tcva_pkg::PDATA_W-tcva_pkg::CODE_W){1'b0}}, r_cfg.off_code};
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/tcva_channel.sv
// ----------------------------------------------------------------------------
// tcva_channel
// Per-channel minimum/maximum tracker and range-step decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcva_channel (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic                            i_last,
    input  wire logic [tcva_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire logic [tcva_pkg::CODE_W-1:0]     i_code,
    input  wire tcva_pkg::t_cfg                  i_cfg,
    output tcva_pkg::t_chan_res                  o_res
);

    logic [tcva_pkg::SAMPLE_W-1:0] r_low_seen;
    logic [tcva_pkg::SAMPLE_W-1:0] r_high_seen;
    logic [tcva_pkg::SAMPLE_W-1:0] n_low_seen;
    logic [tcva_pkg::SAMPLE_W-1:0] n_high_seen;
    logic                          clipped;
    logic                          quiet;

    // Fold the current sample into the running extremes.
    assign n_low_seen  = (i_sample < r_low_seen)  ? i_sample : r_low_seen;
    assign n_high_seen = (i_sample > r_high_seen) ? i_sample : r_high_seen;

    // The trackers restart after the last sample of an acquisition.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_seen  <= tcva_pkg::TRACK_LOW_INIT;
            r_high_seen <= tcva_pkg::TRACK_HIGH_INIT;
        end else if (i_fire) begin
            if (i_last) begin
                r_low_seen  <= tcva_pkg::TRACK_LOW_INIT;
                r_high_seen <= tcva_pkg::TRACK_HIGH_INIT;
            end else begin
                r_low_seen  <= n_low_seen;
                r_high_seen <= n_high_seen;
            end
        end
    end

    assign clipped = (n_low_seen < i_cfg.clip_low) || (n_high_seen > i_cfg.clip_high);
    assign quiet   = (n_low_seen > i_cfg.quiet_low) && (n_high_seen < i_cfg.quiet_high);

    // With ranging on and the code not the off code, step down on clipping, otherwise step up when quiet.
    // Codes wrap within four bits when the limits do not bound them.
    always_comb begin
        o_res.code    = i_code;
        o_res.changed = 1'b0;
        if (i_cfg.ranging_enable && (i_code != i_cfg.off_code)) begin
            if ((i_code != i_cfg.least_sens_code) && clipped) begin
                o_res.code    = i_code - 4'd1;
                o_res.changed = 1'b1;
            end else if ((i_code != i_cfg.most_sens_code) && quiet) begin
                o_res.code    = i_code + 4'd1;
                o_res.changed = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/tcva_checker.sv
// ----------------------------------------------------------------------------
// tcva_checker
// Port-level checks of the autorange block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "two_channel_volt_autorange_core_macros.svh"

module tcva_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [tcva_pkg::CODE_W-1:0]   i_new_code_a,
    input  wire logic [tcva_pkg::CODE_W-1:0]   i_new_code_b,
    input  wire logic                          i_changed_a,
    input  wire logic                          i_changed_b,
    input  wire logic                          i_ranging_done
);

    // A stalled result keeps its value.
    `TCVA_ASSERT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_new_code_a)
            && $stable(i_new_code_b) && $stable(i_changed_a) && $stable(i_changed_b))

    // With ranging off, no code is ever reported as stepped.
    `TCVA_ASSERT(a_no_step_when_off, i_clk, i_rst_n,
        i_out_valid && !i_ranging_done |-> !i_changed_a && !i_changed_b)

    // The input side only stalls behind a full, stalled result slot.
    `TCVA_ASSERT(a_stall_cause, i_clk, i_rst_n,
        !i_in_ready |-> i_out_valid && !i_out_ready)

    // No result right after reset.
    `TCVA_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !i_out_valid)

endmodule

bind two_channel_volt_autorange_core tcva_checker u_tcva_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_new_code_a   (o_out.new_code_a),
    .i_new_code_b   (o_out.new_code_b),
    .i_changed_a    (o_out.changed_a),
    .i_changed_b    (o_out.changed_b),
    .i_ranging_done (o_out.ranging_done)
);

`default_nettype wire
